// File: design/dbcs_pkg.sv
// Shared constants, codes and helpers for the disc brush canvas stamper.
// Standalone package; used by disc_brush_canvas_stamper_unit.
`default_nettype none
package dbcs_pkg;

  localparam int AREA_WIDTH  = 64;
  localparam int AREA_HEIGHT = 32;
  localparam int CELLS       = AREA_WIDTH * AREA_HEIGHT;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int XW          = $clog2(AREA_WIDTH);
  localparam int YW          = $clog2(AREA_HEIGHT);

  localparam logic [7:0] AREA_LEFT_RESET = 8'd5;
  localparam logic [7:0] AREA_TOP_RESET  = 8'd3;

  // commands
  localparam logic [1:0] CMD_STAMP = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // config register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_KIND   = 2'd1;
  localparam logic [1:0] REG_LEFT   = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  // brush kinds
  localparam logic [1:0] KIND_PENCIL = 2'd0;
  localparam logic [1:0] KIND_PEN    = 2'd2;

  // cell codes
  localparam logic [1:0] CELL_BLANK = 2'd0;
  localparam logic [1:0] CELL_STAR  = 2'd1;
  localparam logic [1:0] CELL_PLUS  = 2'd2;

  function automatic logic [1:0] brush_code(input logic [1:0] kind);
    logic [1:0] code;
    case (kind)
      KIND_PENCIL: code = CELL_STAR;
      KIND_PEN:    code = CELL_PLUS;
      default:     code = CELL_BLANK;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// File: design/disc_brush_canvas_stamper_unit.sv
// Disc brush canvas stamper: canvas memory, stamp walker, read and clear.
// Depends on dbcs_pkg for sizes, codes and the brush code table.
//
//  channel | signals                                        | beat when
//  in      | command, screen_col, screen_row, left_button   | in_valid & !in_stall
//  out     | cell_code, inside_area                         | out_valid & !out_stall
//  cfg     | cfg_index, cfg_data                            | cfg_write
//
// Stamp: walks the offset square, writing each offset inside the disc to memory.
// Read: registered memory read. Clear: writes every canvas cell blank.
// Other items go straight to the result. All writes use the single canvas write port.
// After reset the canvas is cleared; in_stall stays high meanwhile.
// A finished result waits in the output register; a new item is taken meanwhile.
`default_nettype none
module disc_brush_canvas_stamper_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [7:0] screen_col,
  input  wire logic [7:0] screen_row,
  input  wire logic       left_button,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      cell_code,
  output logic            inside_area,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_STAMP = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [dbcs_pkg::ADDR_W-1:0] LAST_ADDR =
    dbcs_pkg::ADDR_W'(dbcs_pkg::CELLS - 1);

  logic [2:0] state;

  logic [3:0] brush_radius;
  logic [1:0] brush_kind;
  logic [7:0] area_left;
  logic [7:0] area_top;

  logic [1:0]              cmd;
  logic                    acted;
  logic [dbcs_pkg::XW-1:0] rx;
  logic [dbcs_pkg::YW-1:0] ry;
  logic signed [4:0]       dx;
  logic signed [4:0]       dy;
  logic [dbcs_pkg::ADDR_W-1:0] clr_addr;

  logic [1:0] canvas [dbcs_pkg::CELLS];
  logic [1:0] rd_data;

  // input decode
  logic [8:0] diff_x, diff_y;
  logic       in_x, in_y, in_inside, in_acted, in_take;
  assign diff_x    = {1'b0, screen_col} - {1'b0, area_left};
  assign diff_y    = {1'b0, screen_row} - {1'b0, area_top};
  assign in_x      = !diff_x[8] && ({1'b0, diff_x[7:0]} < 9'(dbcs_pkg::AREA_WIDTH));
  assign in_y      = !diff_y[8] && ({1'b0, diff_y[7:0]} < 9'(dbcs_pkg::AREA_HEIGHT));
  assign in_inside = in_x && in_y;
  assign in_acted  = in_inside &&
                     ((command == dbcs_pkg::CMD_STAMP && left_button) ||
                      command == dbcs_pkg::CMD_READ);
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;

  // stamp offset test and clamped target
  logic [3:0] ax, ay;
  logic [8:0] dist_sq, limit;
  logic       hit, dx_last, dy_last;
  logic signed [9:0] sx, sy;
  logic [dbcs_pkg::XW-1:0] tx;
  logic [dbcs_pkg::YW-1:0] ty;
  logic [dbcs_pkg::ADDR_W-1:0] stamp_addr, read_addr;

  assign ax      = dx[4] ? 4'(-dx) : 4'(dx);
  assign ay      = dy[4] ? 4'(-dy) : 4'(dy);
  assign dist_sq = 9'(ax * ax) + 9'(ay * ay);
  assign limit   = 9'(brush_radius * brush_radius) + 9'(brush_radius);
  assign hit     = dist_sq < limit;
  assign dx_last = (dx == $signed({1'b0, brush_radius}));
  assign dy_last = (dy == $signed({1'b0, brush_radius}));

  assign sx = $signed(10'(rx)) + 10'(dx);
  assign sy = $signed(10'(ry)) + 10'(dy);

  always_comb begin
    if (sx < 10'sd0) begin
      tx = '0;
    end else if (sx > $signed(10'(dbcs_pkg::AREA_WIDTH - 1))) begin
      tx = dbcs_pkg::XW'(dbcs_pkg::AREA_WIDTH - 1);
    end else begin
      tx = sx[dbcs_pkg::XW-1:0];
    end
    if (sy < 10'sd0) begin
      ty = '0;
    end else if (sy > $signed(10'(dbcs_pkg::AREA_HEIGHT - 1))) begin
      ty = dbcs_pkg::YW'(dbcs_pkg::AREA_HEIGHT - 1);
    end else begin
      ty = sy[dbcs_pkg::YW-1:0];
    end
  end

  assign stamp_addr = dbcs_pkg::ADDR_W'(
    dbcs_pkg::ADDR_W'(ty) * dbcs_pkg::ADDR_W'(dbcs_pkg::AREA_WIDTH) +
    dbcs_pkg::ADDR_W'(tx));
  assign read_addr = dbcs_pkg::ADDR_W'(
    dbcs_pkg::ADDR_W'(ry) * dbcs_pkg::ADDR_W'(dbcs_pkg::AREA_WIDTH) +
    dbcs_pkg::ADDR_W'(rx));

  // canvas write port
  logic                        we;
  logic [dbcs_pkg::ADDR_W-1:0] wa;
  logic [1:0]                  wd;
  always_comb begin
    we = 1'b0;
    wa = clr_addr;
    wd = dbcs_pkg::CELL_BLANK;
    case (state)
      ST_INIT, ST_CLEAR: begin
        we = 1'b1;
      end
      ST_STAMP: begin
        we = hit;
        wa = stamp_addr;
        wd = dbcs_pkg::brush_code(brush_kind);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      canvas[wa] <= wd;
    end
    if (state == ST_READ) begin
      rd_data <= canvas[read_addr];
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      brush_radius <= '0;
      brush_kind   <= dbcs_pkg::KIND_PENCIL;
      area_left    <= dbcs_pkg::AREA_LEFT_RESET;
      area_top     <= dbcs_pkg::AREA_TOP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dbcs_pkg::REG_RADIUS: brush_radius <= cfg_data[3:0];
        dbcs_pkg::REG_KIND:   brush_kind   <= cfg_data[1:0];
        dbcs_pkg::REG_LEFT:   area_left    <= cfg_data;
        dbcs_pkg::REG_TOP:    area_top     <= cfg_data;
        default: ;
      endcase
    end
  end

  // item fields
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd   <= command;
      acted <= in_acted;
      rx    <= diff_x[dbcs_pkg::XW-1:0];
      ry    <= diff_y[dbcs_pkg::YW-1:0];
    end
  end

  // sequencer
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      clr_addr <= '0;
      dx       <= '0;
      dy       <= '0;
    end else begin
      case (state)
        ST_INIT: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            clr_addr <= '0;
            dx       <= -$signed({1'b0, brush_radius});
            dy       <= -$signed({1'b0, brush_radius});
            if (command == dbcs_pkg::CMD_CLEAR) begin
              state <= ST_CLEAR;
            end else if (in_acted && command == dbcs_pkg::CMD_STAMP) begin
              state <= ST_STAMP;
            end else if (in_acted) begin
              state <= ST_READ;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_STAMP: begin
          if (dx_last) begin
            dx <= -$signed({1'b0, brush_radius});
            dy <= dy + 5'sd1;
            if (dy_last) begin
              state <= ST_FIN;
            end
          end else begin
            dx <= dx + 5'sd1;
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_FIN;
          end
        end
        ST_READ: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      inside_area <= acted;
      cell_code   <= (acted && cmd == dbcs_pkg::CMD_READ) ? rd_data : dbcs_pkg::CELL_BLANK;
    end
  end

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Testbench for disc_brush_canvas_stamper_unit: directed table, then random phases
// of stamp/read/clear beats checked against a behavioral canvas model. Uses dbcs_pkg.
`default_nettype none
module tb_top;
  import dbcs_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam logic [1:0] KIND_ERASER = 2'd1;
  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam int RANDOM_ITEMS = 580;
  localparam int QUIET_AFTER  = 520;
  localparam int CYCLE_LIMIT  = 6000000;

  typedef struct packed {
    logic [1:0] code;
    logic       in_area;
  } result_t;

  // for configuration rows cmd holds the register index and col the data
  typedef struct packed {
    logic       is_cfg;
    logic [1:0] cmd;
    logic [7:0] col;
    logic [7:0] row;
    logic       btn;
    logic       typed;
    logic [1:0] code;
    logic       in_area;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] command;
  logic [7:0] screen_col;
  logic [7:0] screen_row;
  logic       left_button;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] cell_code;
  logic       inside_area;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  logic [1:0] shadow_canvas [CELLS];
  logic [3:0] radius_q;
  logic [1:0] kind_q;
  logic [7:0] left_q;
  logic [7:0] top_q;

  result_t   pending_results [$];
  plan_row_t directed_plan [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        quiet = 1'b0;
  bit        gaps_on = 1'b1;
  bit        stall_on = 1'b1;

  disc_brush_canvas_stamper_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .screen_col(screen_col), .screen_row(screen_row),
    .left_button(left_button),
    .out_valid(out_valid), .out_stall(out_stall),
    .cell_code(cell_code), .inside_area(inside_area),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result beats are compared in order against the predicted queue
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected beat: code=%0d inside=%0d", cell_code, inside_area);
      end else begin
        exp_r = pending_results.pop_front();
        if (cell_code !== exp_r.code || inside_area !== exp_r.in_area) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected code=%0d inside=%0d, got code=%0d inside=%0d",
                     exp_r.code, exp_r.in_area, cell_code, inside_area);
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && !quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic predict_result(input logic [1:0] cmd, input logic [7:0] col,
                                input logic [7:0] row, input logic btn,
                                output result_t res);
    int rx, ry, r, lim, x, y, dx, dy;
    logic in_area;
    logic [1:0] ink;
    rx = int'(col) - int'(left_q);
    ry = int'(row) - int'(top_q);
    in_area = rx >= 0 && rx < AREA_WIDTH && ry >= 0 && ry < AREA_HEIGHT;
    res = '0;
    case (kind_q)
      KIND_PENCIL: ink = CELL_STAR;
      KIND_PEN:    ink = CELL_PLUS;
      default:     ink = CELL_BLANK;
    endcase
    if (cmd == CMD_STAMP) begin
      if (in_area && btn) begin
        r = int'(radius_q);
        lim = r * r + r;
        for (dy = -r; dy <= r; dy++) begin
          for (dx = -r; dx <= r; dx++) begin
            if (dx * dx + dy * dy < lim) begin
              x = rx + dx;
              y = ry + dy;
              if (x < 0) x = 0;
              else if (x > AREA_WIDTH - 1) x = AREA_WIDTH - 1;
              if (y < 0) y = 0;
              else if (y > AREA_HEIGHT - 1) y = AREA_HEIGHT - 1;
              shadow_canvas[y * AREA_WIDTH + x] = ink;
            end
          end
        end
        res.in_area = 1'b1;
      end
    end else if (cmd == CMD_READ) begin
      if (in_area) begin
        res.code = shadow_canvas[ry * AREA_WIDTH + rx];
        res.in_area = 1'b1;
      end
    end else if (cmd == CMD_CLEAR) begin
      for (x = 0; x < CELLS; x++) shadow_canvas[x] = CELL_BLANK;
    end
  endtask

  // leaves in_valid high after the accepted beat; caller lowers it
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] col,
                           input logic [7:0] row, input logic btn,
                           input logic typed, input logic [1:0] t_code,
                           input logic t_in_area);
    result_t res;
    if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    screen_col  <= col;
    screen_row  <= row;
    left_button <= btn;
    do @(posedge clk); while (in_stall);
    predict_result(cmd, col, row, btn, res);
    if (typed) begin
      res.code = t_code;
      res.in_area = t_in_area;
    end
    pending_results.push_back(res);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_RADIUS: radius_q = data[3:0];
      REG_KIND:   kind_q = data[1:0];
      REG_LEFT:   left_q = data;
      REG_TOP:    top_q = data;
      default:    ;
    endcase
    @(posedge clk);
  endtask

  function automatic void plan_item(logic [1:0] cmd, logic [7:0] col, logic [7:0] row,
                                    logic btn);
    directed_plan.push_back({1'b0, cmd, col, row, btn, 1'b0, 2'd0, 1'b0});
  endfunction

  function automatic void plan_check(logic [1:0] cmd, logic [7:0] col, logic [7:0] row,
                                     logic btn, logic [1:0] code, logic in_area);
    directed_plan.push_back({1'b0, cmd, col, row, btn, 1'b1, code, in_area});
  endfunction

  function automatic void plan_cfg(logic [1:0] idx, logic [7:0] data);
    directed_plan.push_back({1'b1, idx, data, 8'd0, 1'b0, 1'b0, 2'd0, 1'b0});
  endfunction

  // coordinate inside [base, base+span) when it fits on screen, edges favored
  function automatic logic [7:0] pick_coord(input logic [7:0] base, input int span);
    int v;
    case ($urandom_range(0, 5))
      0:       v = int'(base);
      1:       v = int'(base) + span - 1;
      default: v = int'(base) + int'($urandom_range(0, span - 1));
    endcase
    if (v > 255) v = $urandom_range(int'(base), 255);
    return v[7:0];
  endfunction

  initial begin
    plan_row_t pr;
    bit in_cfg;
    int fed, batch, pick, i, v;
    logic [7:0] c, r, last_c, last_r;

    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_SPARE;
    screen_col = 8'd0;
    screen_row = 8'd0;
    left_button = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_RADIUS;
    cfg_data = 8'd0;
    radius_q = 4'd0;
    kind_q = KIND_PENCIL;
    left_q = AREA_LEFT_RESET;
    top_q = AREA_TOP_RESET;
    for (i = 0; i < CELLS; i++) shadow_canvas[i] = CELL_BLANK;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    plan_check(CMD_READ, 8'd5, 8'd3, 1'b0, CELL_BLANK, 1'b1);
    plan_check(CMD_READ, 8'd4, 8'd3, 1'b0, CELL_BLANK, 1'b0);
    plan_check(CMD_READ, 8'd69, 8'd3, 1'b0, CELL_BLANK, 1'b0);
    plan_check(CMD_READ, 8'd68, 8'd34, 1'b0, CELL_BLANK, 1'b1);
    plan_check(CMD_READ, 8'd5, 8'd35, 1'b0, CELL_BLANK, 1'b0);
    plan_check(CMD_STAMP, 8'd10, 8'd10, 1'b1, CELL_BLANK, 1'b1);
    plan_check(CMD_STAMP, 8'd10, 8'd10, 1'b0, CELL_BLANK, 1'b0);
    plan_check(CMD_STAMP, 8'd0, 8'd0, 1'b1, CELL_BLANK, 1'b0);
    plan_check(CMD_SPARE, 8'd255, 8'd255, 1'b1, CELL_BLANK, 1'b0);
    plan_cfg(REG_RADIUS, 8'd15);
    plan_check(CMD_STAMP, 8'd5, 8'd3, 1'b1, CELL_BLANK, 1'b1);
    plan_check(CMD_READ, 8'd5, 8'd3, 1'b0, CELL_STAR, 1'b1);
    plan_item(CMD_READ, 8'd68, 8'd34, 1'b0);
    plan_item(CMD_STAMP, 8'd68, 8'd34, 1'b1);
    plan_cfg(REG_RADIUS, 8'd1);
    plan_cfg(REG_KIND, 8'(KIND_PEN));
    plan_check(CMD_STAMP, 8'd40, 8'd20, 1'b1, CELL_BLANK, 1'b1);
    plan_check(CMD_READ, 8'd40, 8'd20, 1'b0, CELL_PLUS, 1'b1);
    plan_item(CMD_READ, 8'd41, 8'd21, 1'b0);
    plan_cfg(REG_RADIUS, 8'd2);
    plan_cfg(REG_KIND, 8'(KIND_SPARE));
    plan_check(CMD_STAMP, 8'd40, 8'd20, 1'b1, CELL_BLANK, 1'b1);
    plan_check(CMD_READ, 8'd40, 8'd20, 1'b0, CELL_BLANK, 1'b1);
    plan_cfg(REG_KIND, 8'(KIND_ERASER));
    plan_item(CMD_STAMP, 8'd6, 8'd4, 1'b1);
    plan_check(CMD_CLEAR, 8'd255, 8'd255, 1'b1, CELL_BLANK, 1'b0);
    plan_check(CMD_READ, 8'd5, 8'd3, 1'b0, CELL_BLANK, 1'b1);
    plan_cfg(REG_LEFT, 8'd0);
    plan_cfg(REG_TOP, 8'd0);
    plan_check(CMD_READ, 8'd0, 8'd0, 1'b0, CELL_BLANK, 1'b1);
    plan_check(CMD_READ, 8'd64, 8'd31, 1'b0, CELL_BLANK, 1'b0);
    plan_cfg(REG_LEFT, 8'd255);
    plan_cfg(REG_TOP, 8'd255);
    plan_check(CMD_READ, 8'd255, 8'd255, 1'b0, CELL_BLANK, 1'b1);
    plan_check(CMD_READ, 8'd254, 8'd255, 1'b0, CELL_BLANK, 1'b0);

    in_cfg = 1'b0;
    foreach (directed_plan[k]) begin
      pr = directed_plan[k];
      if (pr.is_cfg) begin
        if (!in_cfg) settle();
        write_reg(pr.cmd, pr.col);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) cfg_write <= 1'b0;
        in_cfg = 1'b0;
        send_beat(pr.cmd, pr.col, pr.row, pr.btn, pr.typed, pr.code, pr.in_area);
      end
    end

    fed = 0;
    last_c = 8'd40;
    last_r = 8'd20;
    while (fed < RANDOM_ITEMS) begin
      settle();
      gaps_on = $urandom_range(0, 2) != 0;
      stall_on = $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 9))
        0:       v = 15;
        1, 2:    v = $urandom_range(5, 14);
        default: v = $urandom_range(0, 4);
      endcase
      write_reg(REG_RADIUS, v[7:0]);
      write_reg(REG_KIND, 8'($urandom_range(0, 3)));
      case ($urandom_range(0, 11))
        0:       v = 0;
        1:       v = 255;
        2:       v = $urandom_range(192, 254);
        default: v = $urandom_range(0, 191);
      endcase
      write_reg(REG_LEFT, v[7:0]);
      case ($urandom_range(0, 11))
        0:       v = 0;
        1:       v = 255;
        2:       v = $urandom_range(224, 254);
        default: v = $urandom_range(0, 223);
      endcase
      write_reg(REG_TOP, v[7:0]);
      cfg_write <= 1'b0;

      batch = $urandom_range(15, 45);
      while (batch > 0 && fed < RANDOM_ITEMS) begin
        quiet = fed >= QUIET_AFTER;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          c = pick_coord(left_q, AREA_WIDTH);
          r = pick_coord(top_q, AREA_HEIGHT);
          last_c = c;
          last_r = r;
          send_beat(CMD_STAMP, c, r, 1'b1, 1'b0, CELL_BLANK, 1'b0);
        end else if (pick < 60) begin
          v = int'(last_c) + int'($urandom_range(0, 8)) - 4;
          c = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
          v = int'(last_r) + int'($urandom_range(0, 8)) - 4;
          r = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
          send_beat(CMD_READ, c, r, 1'($urandom), 1'b0, CELL_BLANK, 1'b0);
        end else if (pick < 75) begin
          c = pick_coord(left_q, AREA_WIDTH);
          r = pick_coord(top_q, AREA_HEIGHT);
          send_beat(CMD_READ, c, r, 1'($urandom), 1'b0, CELL_BLANK, 1'b0);
        end else if (pick < 78) begin
          send_beat(CMD_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom),
                    1'b0, CELL_BLANK, 1'b0);
        end else if (pick < 88) begin
          send_beat(CMD_STAMP, 8'($urandom), 8'($urandom), 1'($urandom),
                    1'b0, CELL_BLANK, 1'b0);
        end else if (pick < 95) begin
          send_beat(CMD_READ, 8'($urandom), 8'($urandom), 1'($urandom),
                    1'b0, CELL_BLANK, 1'b0);
        end else begin
          send_beat(CMD_SPARE, 8'($urandom), 8'($urandom), 1'($urandom),
                    1'b0, CELL_BLANK, 1'b0);
        end
        fed = fed + 1;
        batch = batch - 1;
      end
    end

    quiet = 1'b1;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
